/* rtl/ifmt_pkg.sv */
// Shared types, constants and character helpers for the integer-to-ASCII formatter.
package ifmt_pkg;

  // Word width for the decimal, hex and pointer kinds.
  localparam int WORD_BITS = 32;
  // Working number width; the 64-bit kind splits into two words of this size.
  localparam int NUM_W     = 32;
  localparam int MAX_CHARS = 16;
  localparam int DEPTH_W   = $clog2(MAX_CHARS + 1);
  localparam int IDX_W     = $clog2(MAX_CHARS);
  localparam int CNT_W     = 4;
  // Zero padding of the lower word when the upper word is printed.
  localparam logic [CNT_W-1:0] LO_PAD_DIGITS = 4'd8;

  // Reciprocal of ten: (n * RECIP10) >> RECIP_SHIFT is n / 10 for any 32-bit n.
  localparam logic [NUM_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  // Conversion kinds.
  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEX  = 3'd2,
    OP_PTR  = 3'd3,
    OP_HEX64 = 3'd4
  } op_e;

  // Text pushed after the digits (it comes out ahead of them).
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_MINUS,
    TAIL_HEX,
    TAIL_NIL
  } tail_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_TAIL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Request to the digit unit.
  typedef struct packed {
    logic             start;
    logic             decimal;
    logic [NUM_W-1:0] num;
  } div_req_t;

  // Response from the digit unit.
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [3:0]       digit;
  } div_rsp_t;

  // ASCII code of one digit, lowercase for hex.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = 8'h61 + {4'd0, d} - 8'd10;
    end else begin
      c = 8'h30 + {4'd0, d};
    end
    return c;
  endfunction

  // Number of tail characters.
  function automatic logic [2:0] tail_len(input tail_e t);
    logic [2:0] n;
    case (t)
      TAIL_NONE:  n = 3'd0;
      TAIL_MINUS: n = 3'd1;
      TAIL_HEX:   n = 3'd2;
      TAIL_NIL:   n = 3'd5;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  // Tail characters in push order, which is the reverse of print order.
  function automatic logic [7:0] tail_char(input tail_e t, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h30;
    case (t)
      TAIL_MINUS: c = 8'h2D;
      TAIL_HEX: begin
        if (idx == 3'd0) begin
          c = 8'h78;
        end else begin
          c = 8'h30;
        end
      end
      TAIL_NIL: begin
        case (idx)
          3'd0:    c = 8'h29;
          3'd1:    c = 8'h6C;
          3'd2:    c = 8'h69;
          3'd3:    c = 8'h6E;
          default: c = 8'h28;
        endcase
      end
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ifmt_digit_unit.sv */
// Shared digit unit: splits off the lowest decimal or hex digit of a number.
module ifmt_digit_unit (
  input  logic              clk,
  input  logic              rst,
  input  ifmt_pkg::div_req_t req,
  output ifmt_pkg::div_rsp_t rsp
);

  logic                         s1_valid;
  logic                         s1_decimal;
  logic [ifmt_pkg::NUM_W-1:0]   s1_num;
  logic [2*ifmt_pkg::NUM_W-1:0] s1_prod;
  logic [ifmt_pkg::NUM_W-1:0]   quot_calc;
  logic [ifmt_pkg::NUM_W-1:0]   quot_x10;
  logic [ifmt_pkg::NUM_W-1:0]   rem_calc;
  logic                         done;
  logic [ifmt_pkg::NUM_W-1:0]   quot;
  logic [3:0]                   digit;

  // Stage 1: capture the number and its product with the reciprocal of ten.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.start;
    end
    if (req.start) begin
      s1_decimal <= req.decimal;
      s1_num     <= req.num;
      s1_prod    <= req.num * ifmt_pkg::RECIP10;
    end
  end

  // Stage 2: quotient (product or nibble shift), remainder (subtract or low nibble)
  always_comb begin
    if (s1_decimal) begin
      quot_calc = ifmt_pkg::NUM_W'(s1_prod[2*ifmt_pkg::NUM_W-1:ifmt_pkg::RECIP_SHIFT]);
    end else begin
      quot_calc = s1_num >> 4;
    end
    quot_x10 = (quot_calc << 3) + (quot_calc << 1);
    if (s1_decimal) begin
      rem_calc = s1_num - quot_x10;
    end else begin
      rem_calc = {{(ifmt_pkg::NUM_W-4){1'b0}}, s1_num[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      quot  <= quot_calc;
      digit <= rem_calc[3:0];
    end
  end

  assign rsp.done  = done;
  assign rsp.quot  = quot;
  assign rsp.digit = digit;

endmodule

/* rtl/ifmt_char_stack.sv */
// Character stack: text is pushed last character first and popped in print order.
module ifmt_char_stack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [7:0]                   push_char,
  input  logic                         pop,
  output logic [7:0]                   top,
  output logic [ifmt_pkg::DEPTH_W-1:0] depth
);

  logic [7:0]                   entries [ifmt_pkg::MAX_CHARS];
  logic [ifmt_pkg::DEPTH_W-1:0] top_pos;

  assign top_pos = depth - 1'b1;
  assign top     = entries[top_pos[ifmt_pkg::IDX_W-1:0]];

  // Track the fill level; a full stack drops further pushes.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (push && depth != ifmt_pkg::DEPTH_W'(ifmt_pkg::MAX_CHARS)) begin
      depth <= depth + 1'b1;
    end else if (pop && depth != '0) begin
      depth <= depth - 1'b1;
    end
  end

  // Write the pushed character above the current top.
  always_ff @(posedge clk) begin
    if (push && depth != ifmt_pkg::DEPTH_W'(ifmt_pkg::MAX_CHARS)) begin
      entries[depth[ifmt_pkg::IDX_W-1:0]] <= push_char;
    end
  end

endmodule

/* rtl/integer_to_ascii_formatter_core.sv */
// Top level of the integer-to-ASCII formatter: sequencer, digit unit and character stack.
//
// Input channel in_valid/in_ready/in_data carries one transaction per value: a conversion
// kind (signed decimal, unsigned decimal, hex, pointer, 64-bit hex) and a 64-bit value.
// Output channel out_valid/out_ready/out_data returns the text one ASCII character per
// transaction, most significant first, with last set on the final character.
// A value is converted digit by digit through one shared digit unit (multiply by the
// reciprocal of ten, or a nibble shift for hex). The characters land on a stack and are
// then popped out at one per cycle while the receiver is ready. in_ready is high only while
// the block is idle; a value with an unknown kind is accepted and produces no output.
// A stalled receiver holds the current character on out_data and the block waits.
// Reset (rst, synchronous) returns the sequencer to idle and empties the stack;
// no clearing pass is needed.
module integer_to_ascii_formatter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ifmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ifmt_pkg::out_item_t out_data
);

  ifmt_pkg::state_e              state;
  ifmt_pkg::state_e              state_next;
  ifmt_pkg::tail_e               tail;
  logic                          decimal;
  logic [ifmt_pkg::NUM_W-1:0]    num;
  logic [ifmt_pkg::NUM_W-1:0]    hi_word;
  logic                          second;
  logic [ifmt_pkg::CNT_W-1:0]    min_digits;
  logic [ifmt_pkg::CNT_W-1:0]    digit_cnt;
  logic [ifmt_pkg::CNT_W-1:0]    cnt_inc;
  logic [2:0]                    tidx;

  logic [ifmt_pkg::WORD_BITS-1:0] word;
  logic [ifmt_pkg::WORD_BITS-1:0] word_neg;
  logic [ifmt_pkg::NUM_W-1:0]     in_hi;
  logic [ifmt_pkg::NUM_W-1:0]     in_lo;
  logic                           more_digits;
  logic                           accept;

  ifmt_pkg::div_req_t            div_req;
  ifmt_pkg::div_rsp_t            div_rsp;

  logic                          push;
  logic [7:0]                    push_char;
  logic                          pop;
  logic [7:0]                    stack_top;
  logic [ifmt_pkg::DEPTH_W-1:0]  depth;

  ifmt_digit_unit u_digit (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ifmt_char_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_char (push_char),
    .pop       (pop),
    .top       (stack_top),
    .depth     (depth)
  );

  // Decode the incoming value.
  assign word     = in_data.value[ifmt_pkg::WORD_BITS-1:0];
  assign word_neg = ~word + 1'b1;
  assign in_hi    = in_data.value[63:32];
  assign in_lo    = in_data.value[31:0];
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = digit_cnt + 1'b1;
  assign more_digits = (div_rsp.quot != '0) || (cnt_inc < min_digits);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ifmt_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            ifmt_pkg::OP_SDEC, ifmt_pkg::OP_UDEC, ifmt_pkg::OP_HEX,
            ifmt_pkg::OP_HEX64: state_next = ifmt_pkg::S_START;
            ifmt_pkg::OP_PTR: begin
              if (word == '0) begin
                state_next = ifmt_pkg::S_TAIL;
              end else begin
                state_next = ifmt_pkg::S_START;
              end
            end
            default: state_next = ifmt_pkg::S_IDLE;
          endcase
        end
      end
      ifmt_pkg::S_START: state_next = ifmt_pkg::S_WAIT;
      ifmt_pkg::S_WAIT: begin
        if (div_rsp.done) begin
          if (more_digits || second) begin
            state_next = ifmt_pkg::S_START;
          end else if (tail != ifmt_pkg::TAIL_NONE) begin
            state_next = ifmt_pkg::S_TAIL;
          end else begin
            state_next = ifmt_pkg::S_EMIT;
          end
        end
      end
      ifmt_pkg::S_TAIL: begin
        if (tidx == ifmt_pkg::tail_len(tail) - 3'd1) begin
          state_next = ifmt_pkg::S_EMIT;
        end
      end
      ifmt_pkg::S_EMIT: begin
        if (out_ready && depth == ifmt_pkg::DEPTH_W'(1)) begin
          state_next = ifmt_pkg::S_IDLE;
        end
      end
      default: state_next = ifmt_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    push            = 1'b0;
    push_char       = ifmt_pkg::digit_char(div_rsp.digit);
    pop             = 1'b0;
    div_req.start   = 1'b0;
    div_req.decimal = decimal;
    div_req.num     = num;
    case (state)
      ifmt_pkg::S_IDLE:  in_ready = 1'b1;
      ifmt_pkg::S_START: div_req.start = 1'b1;
      ifmt_pkg::S_WAIT:  push = div_rsp.done;
      ifmt_pkg::S_TAIL: begin
        push      = 1'b1;
        push_char = ifmt_pkg::tail_char(tail, tidx);
      end
      ifmt_pkg::S_EMIT: begin
        out_valid = 1'b1;
        pop       = out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign out_data.character = stack_top;
  assign out_data.last      = (depth == ifmt_pkg::DEPTH_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load the work registers on a new value, then advance them per digit and tail char.
  always_ff @(posedge clk) begin
    if (accept) begin
      digit_cnt  <= '0;
      tidx       <= '0;
      second     <= 1'b0;
      min_digits <= ifmt_pkg::CNT_W'(1);
      hi_word    <= in_hi;
      decimal    <= 1'b0;
      num        <= ifmt_pkg::NUM_W'(word);
      tail       <= ifmt_pkg::TAIL_NONE;
      case (in_data.operation)
        ifmt_pkg::OP_SDEC: begin
          decimal <= 1'b1;
          if (word[ifmt_pkg::WORD_BITS-1]) begin
            num  <= ifmt_pkg::NUM_W'(word_neg);
            tail <= ifmt_pkg::TAIL_MINUS;
          end
        end
        ifmt_pkg::OP_UDEC: decimal <= 1'b1;
        ifmt_pkg::OP_PTR: begin
          if (word == '0) begin
            tail <= ifmt_pkg::TAIL_NIL;
          end else begin
            tail <= ifmt_pkg::TAIL_HEX;
          end
        end
        ifmt_pkg::OP_HEX64: begin
          num <= in_lo;
          if (in_hi != '0) begin
            second     <= 1'b1;
            min_digits <= ifmt_pkg::LO_PAD_DIGITS;
          end
        end
        default: decimal <= 1'b0;
      endcase
    end else if (state == ifmt_pkg::S_WAIT && div_rsp.done) begin
      if (more_digits) begin
        num       <= div_rsp.quot;
        digit_cnt <= cnt_inc;
      end else if (second) begin
        num        <= hi_word;
        second     <= 1'b0;
        digit_cnt  <= '0;
        min_digits <= ifmt_pkg::CNT_W'(1);
      end
    end else if (state == ifmt_pkg::S_TAIL) begin
      tidx <= tidx + 1'b1;
    end
  end

  // The input side is closed while characters are pending.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (depth != '0) |-> !in_ready)
    else $error("input accepted while characters are still pending");

  // The final character returns the block to idle.
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> (in_ready && depth == '0))
    else $error("block not idle after last character");

  // The digit unit answers only while the sequencer waits for it.
  a_digit_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ifmt_pkg::S_WAIT))
    else $error("digit result outside the wait state");

  // Output is only presented with characters on the stack.
  a_valid_has_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (depth != '0))
    else $error("output valid with an empty stack");

endmodule
